FILE: hdl/yuvbgra_pkg.sv
// Package for yuv420_pair_to_bgra: register indexes, reset values and datapath widths.
// Depends on nothing; imported by the top level.
package yuvbgra_pkg;

   // default fraction width of the fixed-point gains
   localparam int FRAC_BITS_DEFAULT = 14;

   // configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_OFFSET     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LUMA_OFFSET       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LUMA_GAIN         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_FROM_U_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_FROM_U_GAIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_FROM_V_GAIN = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_FROM_V_GAIN   = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_CHROMA_OFFSET     = 8'd128;
   localparam logic [7:0]  RST_LUMA_OFFSET       = 8'd16;
   localparam logic [15:0] RST_LUMA_GAIN         = 16'd19071;
   localparam logic [15:0] RST_BLUE_FROM_U_GAIN  = 16'd33050;
   localparam logic [15:0] RST_GREEN_FROM_U_GAIN = 16'd6406;
   localparam logic [15:0] RST_GREEN_FROM_V_GAIN = 16'd13320;
   localparam logic [15:0] RST_RED_FROM_V_GAIN   = 16'd26149;

   // datapath widths: offset-removed sample, gain*sample product, green pair sum, channel sum
   localparam int DIFF_W = 9;
   localparam int PROD_W = 25;
   localparam int GSUM_W = 26;
   localparam int SUM_W  = 28;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // one pixel's rounded channel sums
   typedef struct packed {
      logic signed [SUM_W-1:0] blue;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] red;
   } chan_sum_type;

endpackage

FILE: hdl/yuv420_pair_to_bgra.sv
// Top level of yuv420_pair_to_bgra: 4:2:0 chroma pair plus two luma samples to two BGRA pixels.
// Depends on yuvbgra_pkg for register indexes, reset values and widths.
//
//   channel   ports                    beat accepted when
//   --------  -----------------------  ----------------------------------
//   request   start, busy, req_*       start high and busy low at a clock edge
//   response  rsp_strobe, rsp_*        rsp_strobe high, one cycle per beat
//   config    csr_write_enable, csr_*  csr_write_enable high at a clock edge
//
// A beat enters every cycle; busy is held low. Five register stages: offset removal,
// multiplication, green sum and luma rounding, channel sums, clamp and pack.
// A result strobes once its request beat has passed through all the register stages.
// Synchronous reset clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module yuv420_pair_to_bgra #(
   parameter int FRAC_BITS = yuvbgra_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [7:0]                          req_luma_first,
   input  logic [7:0]                          req_luma_second,
   input  logic [7:0]                          req_chroma_blue,
   input  logic [7:0]                          req_chroma_red,
   input  logic                                req_second_present,
   output logic                                rsp_strobe,
   output logic [31:0]                         rsp_pixel_first_bgra,
   output logic [31:0]                         rsp_pixel_second_bgra,
   output logic                                rsp_second_valid,
   input  logic                                csr_write_enable,
   input  logic [yuvbgra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [yuvbgra_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import yuvbgra_pkg::*;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   // configuration registers
   logic [7:0]  chroma_offset_ff, luma_offset_ff;
   logic [15:0] luma_gain_ff, blue_u_gain_ff, green_u_gain_ff, green_v_gain_ff, red_v_gain_ff;

   // write configuration; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         chroma_offset_ff <= RST_CHROMA_OFFSET;
         luma_offset_ff   <= RST_LUMA_OFFSET;
         luma_gain_ff     <= RST_LUMA_GAIN;
         blue_u_gain_ff   <= RST_BLUE_FROM_U_GAIN;
         green_u_gain_ff  <= RST_GREEN_FROM_U_GAIN;
         green_v_gain_ff  <= RST_GREEN_FROM_V_GAIN;
         red_v_gain_ff    <= RST_RED_FROM_V_GAIN;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_CHROMA_OFFSET:     chroma_offset_ff <= csr_write_data[7:0];
            REG_LUMA_OFFSET:       luma_offset_ff   <= csr_write_data[7:0];
            REG_LUMA_GAIN:         luma_gain_ff     <= csr_write_data;
            REG_BLUE_FROM_U_GAIN:  blue_u_gain_ff   <= csr_write_data;
            REG_GREEN_FROM_U_GAIN: green_u_gain_ff  <= csr_write_data;
            REG_GREEN_FROM_V_GAIN: green_v_gain_ff  <= csr_write_data;
            REG_RED_FROM_V_GAIN:   red_v_gain_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // valid bits of the stages
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: remove offsets
   logic signed [DIFF_W-1:0] u_in, v_in, y0_in, y1_in;
   logic signed [DIFF_W-1:0] u_ff, v_ff, y0_ff, y1_ff;
   logic                     s1_second_ff;

   assign u_in  = $signed({1'b0, req_chroma_blue})  - $signed({1'b0, chroma_offset_ff});
   assign v_in  = $signed({1'b0, req_chroma_red})   - $signed({1'b0, chroma_offset_ff});
   assign y0_in = $signed({1'b0, req_luma_first})   - $signed({1'b0, luma_offset_ff});
   assign y1_in = $signed({1'b0, req_luma_second})  - $signed({1'b0, luma_offset_ff});

   always_ff @(posedge clock) begin
      u_ff         <= u_in;
      v_ff         <= v_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      s1_second_ff <= req_second_present;
   end

   // stage 2: six gain products
   logic signed [16:0] luma_gain_s, blue_u_gain_s, green_u_gain_s, green_v_gain_s, red_v_gain_s;
   logic signed [PROD_W-1:0] bterm_in, gu_in, gv_in, rterm_in, luma0_in, luma1_in;
   logic signed [PROD_W-1:0] bterm_ff, gu_ff, gv_ff, rterm_ff, luma0_ff, luma1_ff;
   logic                     s2_second_ff;

   assign luma_gain_s    = $signed({1'b0, luma_gain_ff});
   assign blue_u_gain_s  = $signed({1'b0, blue_u_gain_ff});
   assign green_u_gain_s = $signed({1'b0, green_u_gain_ff});
   assign green_v_gain_s = $signed({1'b0, green_v_gain_ff});
   assign red_v_gain_s   = $signed({1'b0, red_v_gain_ff});

   assign bterm_in = blue_u_gain_s * u_ff;
   assign gu_in    = green_u_gain_s * u_ff;
   assign gv_in    = green_v_gain_s * v_ff;
   assign rterm_in = red_v_gain_s * v_ff;
   assign luma0_in = luma_gain_s * y0_ff;
   assign luma1_in = luma_gain_s * y1_ff;

   always_ff @(posedge clock) begin
      bterm_ff     <= bterm_in;
      gu_ff        <= gu_in;
      gv_ff        <= gv_in;
      rterm_ff     <= rterm_in;
      luma0_ff     <= luma0_in;
      luma1_ff     <= luma1_in;
      s2_second_ff <= s1_second_ff;
   end

   // stage 3: negated green term, luma plus rounding half
   logic signed [GSUM_W-1:0] gterm_in, gterm_ff;
   logic signed [SUM_W-1:0]  lr0_in, lr1_in, lr0_ff, lr1_ff;
   logic signed [SUM_W-1:0]  bterm3_ff, rterm3_ff;
   logic                     s3_second_ff;

   assign gterm_in = -(GSUM_W'(gu_ff) + GSUM_W'(gv_ff));
   assign lr0_in   = SUM_W'(luma0_ff) + ROUND_HALF;
   assign lr1_in   = SUM_W'(luma1_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      gterm_ff     <= gterm_in;
      lr0_ff       <= lr0_in;
      lr1_ff       <= lr1_in;
      bterm3_ff    <= SUM_W'(bterm_ff);
      rterm3_ff    <= SUM_W'(rterm_ff);
      s3_second_ff <= s2_second_ff;
   end

   // stage 4: channel sums of both pixels
   chan_sum_type px0_in, px1_in, px0_ff, px1_ff;
   logic         s4_second_ff;

   always_comb begin
      px0_in.blue  = lr0_ff + bterm3_ff;
      px0_in.green = lr0_ff + SUM_W'(gterm_ff);
      px0_in.red   = lr0_ff + rterm3_ff;
      px1_in.blue  = lr1_ff + bterm3_ff;
      px1_in.green = lr1_ff + SUM_W'(gterm_ff);
      px1_in.red   = lr1_ff + rterm3_ff;
   end

   always_ff @(posedge clock) begin
      px0_ff       <= px0_in;
      px1_ff       <= px1_in;
      s4_second_ff <= s3_second_ff;
   end

   // stage 5: shift, clamp to a byte, pack
   function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] q;
      q = s >>> FRAC_BITS;
      if (s < 0) begin
         to_byte = 8'd0;
      end else if (|q[SUM_W-1:8]) begin
         to_byte = 8'hFF;
      end else begin
         to_byte = q[7:0];
      end
   endfunction

   logic [31:0] pix0_in, pix1_in, pix0_ff, pix1_ff;
   logic        second_ff;

   assign pix0_in = {ALPHA_OPAQUE, to_byte(px0_ff.red), to_byte(px0_ff.green),
                     to_byte(px0_ff.blue)};
   assign pix1_in = s4_second_ff ? {ALPHA_OPAQUE, to_byte(px1_ff.red), to_byte(px1_ff.green),
                                    to_byte(px1_ff.blue)} : 32'd0;

   always_ff @(posedge clock) begin
      pix0_ff   <= pix0_in;
      pix1_ff   <= pix1_in;
      second_ff <= s4_second_ff;
   end

   assign rsp_strobe            = out_valid_ff;
   assign rsp_pixel_first_bgra  = pix0_ff;
   assign rsp_pixel_second_bgra = pix1_ff;
   assign rsp_second_valid      = second_ff;

   // every accepted beat produces a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_strobe)
      else $error("result beat missing five cycles after request");

   // a strobe always traces back to an accepted beat
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 5))
      else $error("result beat without a request");

   // the second flag follows its own beat through the pipeline
   a_second_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_second_valid == $past(req_second_present, 5)))
      else $error("second pixel flag mismatched");

   // a missing right pixel reads as zero
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_second_valid) |-> (rsp_pixel_second_bgra == 32'd0))
      else $error("absent second pixel not zero");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for yuv420_pair_to_bgra: drives chroma-pair beats, predicts both
// BGRA pixels per beat from its own copy of the registers and checks every result beat.
// Depends on yuvbgra_pkg and the yuv420_pair_to_bgra top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import yuvbgra_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
   localparam int LATENCY      = 5;
   localparam int QUIET_LIMIT  = 4000;

   // index past the register list; writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       second_present;
      bit         drain_first;
   } pair_beat_type;

   typedef struct {
      logic [31:0] first_bgra;
      logic [31:0] second_bgra;
      logic        second_valid;
   } pixel_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [7:0]             req_luma_first = '0;
   logic [7:0]             req_luma_second = '0;
   logic [7:0]             req_chroma_blue = '0;
   logic [7:0]             req_chroma_red = '0;
   logic                   req_second_present = 1'b0;
   logic                   rsp_strobe;
   logic [31:0]            rsp_pixel_first_bgra;
   logic [31:0]            rsp_pixel_second_bgra;
   logic                   rsp_second_valid;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // register shadow used for prediction
   logic [7:0]  cfg_chroma_offset = RST_CHROMA_OFFSET;
   logic [7:0]  cfg_luma_offset   = RST_LUMA_OFFSET;
   logic [15:0] cfg_luma_gain     = RST_LUMA_GAIN;
   logic [15:0] cfg_blue_u_gain   = RST_BLUE_FROM_U_GAIN;
   logic [15:0] cfg_green_u_gain  = RST_GREEN_FROM_U_GAIN;
   logic [15:0] cfg_green_v_gain  = RST_GREEN_FROM_V_GAIN;
   logic [15:0] cfg_red_v_gain    = RST_RED_FROM_V_GAIN;

   pair_beat_type  pair_beats_q[$];
   pixel_pair_type pixel_pairs_due[$];
   pair_beat_type  held_beat;
   int             sender_idle_pct = 0;
   int             in_flight = 0;
   int             burst_left = 0;
   int             quiet_cycles = 0;
   int             errors = 0;

   yuv420_pair_to_bgra #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_luma_first        (req_luma_first),
      .req_luma_second       (req_luma_second),
      .req_chroma_blue       (req_chroma_blue),
      .req_chroma_red        (req_chroma_red),
      .req_second_present    (req_second_present),
      .rsp_strobe            (rsp_strobe),
      .rsp_pixel_first_bgra  (rsp_pixel_first_bgra),
      .rsp_pixel_second_bgra (rsp_pixel_second_bgra),
      .rsp_second_valid      (rsp_second_valid),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // round half up, floor-shift out the fraction, clamp to a byte
   function automatic logic [7:0] round_clamp_channel(longint sum);
      longint rounded;
      rounded = sum + (longint'(1) << (FRAC_BITS - 1));
      if (rounded < 0) return 8'd0;
      rounded = rounded >>> FRAC_BITS;
      if (rounded > 255) return 8'hFF;
      return rounded[7:0];
   endfunction

   function automatic logic [31:0] convert_pixel(logic [7:0] luma_sample, longint blue_term,
                                                 longint green_term, longint red_term);
      longint luma;
      luma = longint'(cfg_luma_gain) * (longint'(luma_sample) - longint'(cfg_luma_offset));
      return {ALPHA_OPAQUE, round_clamp_channel(luma + red_term),
              round_clamp_channel(luma + green_term), round_clamp_channel(luma + blue_term)};
   endfunction

   // chroma terms are shared by both pixels of the pair
   function automatic pixel_pair_type predict_pixel_pair(pair_beat_type beat);
      longint         u_diff;
      longint         v_diff;
      longint         blue_term;
      longint         green_term;
      longint         red_term;
      pixel_pair_type pix;
      u_diff     = longint'(beat.chroma_blue) - longint'(cfg_chroma_offset);
      v_diff     = longint'(beat.chroma_red) - longint'(cfg_chroma_offset);
      blue_term  = longint'(cfg_blue_u_gain) * u_diff;
      green_term = -(longint'(cfg_green_u_gain) * u_diff + longint'(cfg_green_v_gain) * v_diff);
      red_term   = longint'(cfg_red_v_gain) * v_diff;
      pix.first_bgra   = convert_pixel(beat.luma_first, blue_term, green_term, red_term);
      pix.second_bgra  = beat.second_present ?
                         convert_pixel(beat.luma_second, blue_term, green_term, red_term) : '0;
      pix.second_valid = beat.second_present;
      return pix;
   endfunction

   // favor the rails and the neighborhood of the offset
   function automatic logic [7:0] pick_sample(logic [7:0] offset);
      case ($urandom_range(9))
         0: begin
            return 8'd0;
         end
         1: begin
            return 8'hFF;
         end
         2: begin
            return offset + 8'($urandom_range(4)) - 8'd2;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   function automatic void queue_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] u,
                                      logic [7:0] v, logic second, bit drain);
      pair_beat_type beat;
      beat.luma_first     = y0;
      beat.luma_second    = y1;
      beat.chroma_blue    = u;
      beat.chroma_red     = v;
      beat.second_present = second;
      beat.drain_first    = drain;
      pair_beats_q.push_back(beat);
   endfunction

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_CHROMA_OFFSET:     cfg_chroma_offset = data[7:0];
         REG_LUMA_OFFSET:       cfg_luma_offset   = data[7:0];
         REG_LUMA_GAIN:         cfg_luma_gain     = data;
         REG_BLUE_FROM_U_GAIN:  cfg_blue_u_gain   = data;
         REG_GREEN_FROM_U_GAIN: cfg_green_u_gain  = data;
         REG_GREEN_FROM_V_GAIN: cfg_green_v_gain  = data;
         REG_RED_FROM_V_GAIN:   cfg_red_v_gain    = data;
         default: begin
         end
      endcase
   endtask

   task automatic program_config(logic [15:0] chroma_off, logic [15:0] luma_off,
                                 logic [15:0] luma_gain, logic [15:0] blue_u,
                                 logic [15:0] green_u, logic [15:0] green_v,
                                 logic [15:0] red_v);
      write_register(REG_UNMAPPED, 16'($urandom));
      write_register(REG_CHROMA_OFFSET, chroma_off);
      write_register(REG_LUMA_OFFSET, luma_off);
      write_register(REG_LUMA_GAIN, luma_gain);
      write_register(REG_BLUE_FROM_U_GAIN, blue_u);
      write_register(REG_GREEN_FROM_U_GAIN, green_u);
      write_register(REG_GREEN_FROM_V_GAIN, green_v);
      write_register(REG_RED_FROM_V_GAIN, red_v);
      write_register(REG_UNMAPPED, 16'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait until every beat is sent and every pixel pair is back, then let the pipe empty
   task automatic settle_pipeline();
      @(negedge clock);
      while (pair_beats_q.size() != 0 || in_flight != 0 || start) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int count);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      repeat (count) begin
         queue_pair(pick_sample(cfg_luma_offset), pick_sample(cfg_luma_offset),
                    pick_sample(cfg_chroma_offset), pick_sample(cfg_chroma_offset),
                    $urandom_range(3) != 0, $urandom_range(63) == 0);
      end
      settle_pipeline();
   endtask

   // request driver: predict each accepted beat, then launch the next one or idle
   always @(posedge clock) begin : drive_requests
      bit accepted;
      bit launch;
      int outstanding;
      if (reset) begin
         start      <= 1'b0;
         in_flight  <= 0;
         burst_left <= 0;
      end else begin
         accepted = start && !busy;
         if (accepted) pixel_pairs_due.push_back(predict_pixel_pair(held_beat));
         outstanding = in_flight + int'(accepted) - int'(rsp_strobe);
         in_flight <= outstanding;
         if (!(start && busy)) begin
            launch = pair_beats_q.size() != 0 &&
                     (burst_left > 0 || $urandom_range(99) >= sender_idle_pct);
            if (launch && pair_beats_q[0].drain_first && outstanding != 0) launch = 1'b0;
            if (launch) begin
               held_beat = pair_beats_q.pop_front();
               start              <= 1'b1;
               req_luma_first     <= held_beat.luma_first;
               req_luma_second    <= held_beat.luma_second;
               req_chroma_blue    <= held_beat.chroma_blue;
               req_chroma_red     <= held_beat.chroma_red;
               req_second_present <= held_beat.second_present;
            end else begin
               // drive noise on the idle bus
               start              <= 1'b0;
               req_luma_first     <= 8'($urandom);
               req_luma_second    <= 8'($urandom);
               req_chroma_blue    <= 8'($urandom);
               req_chroma_red     <= 8'($urandom);
               req_second_present <= 1'($urandom);
            end
         end
         // occasional back-to-back bursts even in idle-heavy phases
         if (burst_left > 0) begin
            burst_left <= burst_left - 1;
         end else if ($urandom_range(49) == 0) begin
            burst_left <= $urandom_range(40, 8);
         end
      end
   end

   // result monitor: compare each strobed beat with the oldest predicted pair
   always @(posedge clock) begin : check_results
      pixel_pair_type due;
      int             mismatches;
      mismatches = 0;
      if (!reset && rsp_strobe) begin
         if (pixel_pairs_due.size() == 0) begin
            $error("unexpected result beat: first=%h second=%h valid=%b",
                   rsp_pixel_first_bgra, rsp_pixel_second_bgra, rsp_second_valid);
            mismatches = mismatches + 1;
         end else begin
            due = pixel_pairs_due.pop_front();
            if (rsp_pixel_first_bgra !== due.first_bgra) begin
               $error("pixel_first_bgra: expected %h, got %h", due.first_bgra,
                      rsp_pixel_first_bgra);
               mismatches = mismatches + 1;
            end
            if (rsp_pixel_second_bgra !== due.second_bgra) begin
               $error("pixel_second_bgra: expected %h, got %h", due.second_bgra,
                      rsp_pixel_second_bgra);
               mismatches = mismatches + 1;
            end
            if (rsp_second_valid !== due.second_valid) begin
               $error("second_valid: expected %b, got %b", due.second_valid,
                      rsp_second_valid);
               mismatches = mismatches + 1;
            end
         end
         errors <= errors + mismatches;
      end
   end

   // watchdog: end the run when no beat of any kind moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("yuv420_pair_to_bgra regression: fail");
         $finish;
      end
   end

   initial begin : run_regression
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed pairs at the reset settings
      @(negedge clock);
      sender_idle_pct = 0;
      queue_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      queue_pair(8'd16, 8'd235, 8'd128, 8'd128, 1'b1, 1'b0);
      queue_pair(8'd0, 8'hFF, 8'd0, 8'hFF, 1'b1, 1'b0);
      queue_pair(8'hFF, 8'd0, 8'hFF, 8'd0, 1'b1, 1'b0);
      queue_pair(8'd128, 8'd128, 8'd0, 8'd0, 1'b1, 1'b0);
      queue_pair(8'd128, 8'd128, 8'hFF, 8'hFF, 1'b1, 1'b0);
      // right pixel missing
      queue_pair(8'd16, 8'd16, 8'd128, 8'd128, 1'b0, 1'b0);
      queue_pair(8'd200, 8'hFF, 8'd90, 8'd240, 1'b0, 1'b0);
      // sums below zero and past full scale
      queue_pair(8'd0, 8'd15, 8'd0, 8'd0, 1'b1, 1'b0);
      queue_pair(8'hFF, 8'd254, 8'hFF, 8'hFF, 1'b1, 1'b0);
      queue_pair(8'd15, 8'd16, 8'd127, 8'd129, 1'b1, 1'b1);
      queue_pair(8'd235, 8'd236, 8'd240, 8'd16, 1'b1, 1'b0);
      queue_pair(8'd170, 8'd85, 8'd170, 8'd85, 1'b1, 1'b0);
      queue_pair(8'd85, 8'd170, 8'd85, 8'd170, 1'b0, 1'b0);
      run_phase(0, 300);

      // all registers at their low rail
      program_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_phase(87, 250);

      // all registers at their high rail; upper data bits must drop on byte registers
      program_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(0, 300);

      program_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
      run_phase(14, 300);

      // full-range style gains
      program_config(16'd128, 16'd0, 16'd16384, 16'd29032, 16'd5636, 16'd11698, 16'd22970);
      run_phase(87, 300);

      program_config(16'($urandom_range(255)), 16'($urandom_range(255)),
                     16'($urandom_range(40000)), 16'($urandom_range(40000)),
                     16'($urandom_range(40000)), 16'($urandom_range(40000)),
                     16'($urandom_range(40000)));
      run_phase(0, 300);

      @(negedge clock);
      if (pixel_pairs_due.size() != 0) begin
         $error("%0d predicted pixel pairs never returned", pixel_pairs_due.size());
      end
      if (errors == 0 && pixel_pairs_due.size() == 0) begin
         $display("yuv420_pair_to_bgra regression: pass");
      end else begin
         $display("yuv420_pair_to_bgra regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/yuvbgra_pkg.sv
hdl/yuv420_pair_to_bgra.sv
tb/sv/testbench.sv
